>>> hw/rtl/spor_pkg.sv
`default_nettype none
package spor_pkg;

  localparam int MAX_SLOTS_DEF = 16;

  localparam int CFG_W  = 5;
  localparam int SLOT_W = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] SLOTS_RESET = 5'd16;

  localparam logic OP_SPAWN   = 1'b0;
  localparam logic OP_DESPAWN = 1'b1;

  localparam logic REG_SLOTS_IN_USE = 1'b0;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] granted_slot;
    logic              recycled;
  } rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/slot_pool_oldest_recycle_top.sv
// one request at a time: the next is taken only after the result leaves
// a spawn scans the active marks one slot a cycle; if none is free it walks the order list
// one entry a cycle through its two-port ram to the oldest slot below slots_in_use and moves
// it to the end; a removal finds its slot in the list and shifts one entry a cycle
// synchronous reset clears every active mark and the list count, slots_in_use returns to 16;
// the list ram itself is not cleared and needs no clearing pass
`default_nettype none
module slot_pool_oldest_recycle_top #(
  parameter int MAX_SLOTS = spor_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire spor_pkg::req_t                 req_data,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output spor_pkg::rsp_t                      rsp_data,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [spor_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [spor_pkg::PDATA_W-1:0]   pwdata,
  output logic [spor_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import spor_pkg::*;

  logic [CFG_W-1:0] slots_in_use;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_SLOTS_IN_USE);
  assign prdata  = reg_sel ? PDATA_W'(slots_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      slots_in_use <= pwdata[CFG_W-1:0];
    end
  end

  spor_seq #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .slots_in_use(slots_in_use),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_data    (rsp_data)
  );

endmodule
`default_nettype wire

>>> hw/rtl/spor_seq.sv
`default_nettype none
module spor_seq #(
  parameter int MAX_SLOTS = spor_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [spor_pkg::CFG_W-1:0]   slots_in_use,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire spor_pkg::req_t               req_data,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output spor_pkg::rsp_t                    rsp_data
);
  import spor_pkg::*;

  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int NW = (CW > CFG_W) ? CW : CFG_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]           state, state_next;
  logic [CW-1:0]        ptr, ptr_next;
  logic [CW-1:0]        count, count_next;
  logic                 op, op_next;
  logic [SW-1:0]        idx, idx_next;
  logic [SW-1:0]        recyc_slot, recyc_slot_next;
  logic [MAX_SLOTS-1:0] active, active_next;
  rsp_t                 res, res_next;

  // order list ram, one read and one write port
  logic [SW-1:0] order_mem [MAX_SLOTS];
  logic [SW-1:0] rdata;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [SW-1:0] wr_data;

  logic [NW-1:0] live;
  logic [NW-1:0] cfg_ext;
  logic [NW-1:0] max_ext;
  logic [NW-1:0] idx_ext;
  logic [NW-1:0] ptr_ext;
  logic [NW-1:0] rdata_ext;
  logic [NW-1:0] recyc_ext;
  logic [SW-1:0] ptr_a;
  logic          match;

  assign cfg_ext   = NW'(slots_in_use);
  assign max_ext   = NW'(MAX_SLOTS);
  assign live      = (cfg_ext > max_ext) ? max_ext : cfg_ext;
  assign idx_ext   = NW'(req_data.slot_index);
  assign ptr_ext   = NW'(ptr);
  assign ptr_a     = ptr[SW-1:0];
  assign rdata_ext = NW'(rdata);
  assign recyc_ext = NW'(recyc_slot);
  assign match     = (op == OP_SPAWN) ? (rdata_ext < live) : (rdata == idx);

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_DONE);
  assign rsp_data  = res;

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    count_next      = count;
    op_next         = op;
    idx_next        = idx;
    recyc_slot_next = recyc_slot;
    active_next     = active;
    res_next        = res;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = ptr_a;
    wr_data         = rdata;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next  = req_data.op;
          ptr_next = '0;
          res_next = '0;
          if (req_data.op == OP_SPAWN) begin
            state_next = S_SCAN;
          end else if (idx_ext < max_ext) begin
            idx_next = idx_ext[SW-1:0];
            active_next[idx_ext[SW-1:0]] = 1'b0;
            state_next = S_FIND;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (ptr_ext >= live) begin
          ptr_next   = '0;
          state_next = S_FIND;
        end else if (!active[ptr_a]) begin
          active_next[ptr_a] = 1'b1;
          if (count < CW'(MAX_SLOTS)) begin
            wr_en      = 1'b1;
            wr_addr    = count[SW-1:0];
            wr_data    = ptr_a;
            count_next = count + CW'(1);
          end
          res_next.granted      = 1'b1;
          res_next.granted_slot = ptr_ext[SLOT_W-1:0];
          state_next = S_DONE;
        end else begin
          ptr_next = ptr + CW'(1);
        end
      end
      S_FIND: begin
        rd_addr = ptr_a + SW'(1);
        if (ptr >= count) begin
          state_next = S_DONE;
        end else if (match) begin
          recyc_slot_next = rdata;
          state_next = S_SHIFT;
        end else begin
          ptr_next = ptr + CW'(1);
        end
      end
      S_SHIFT: begin
        rd_addr = ptr_a + SW'(2);
        if (ptr + CW'(1) < count) begin
          wr_en    = 1'b1;
          ptr_next = ptr + CW'(1);
        end else begin
          if (op == OP_SPAWN) begin
            wr_en   = 1'b1;
            wr_data = recyc_slot;
            res_next.granted      = 1'b1;
            res_next.granted_slot = recyc_ext[SLOT_W-1:0];
            res_next.recycled     = 1'b1;
          end else begin
            count_next = count - CW'(1);
          end
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      active <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    op         <= op_next;
    idx        <= idx_next;
    recyc_slot <= recyc_slot_next;
    res        <= res_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      order_mem[wr_addr] <= wr_data;
    end
    rdata <= order_mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/spor_checker.sv
`default_nettype none
module spor_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_stall,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire spor_pkg::rsp_t rsp_data
);
  import spor_pkg::*;

  // one request in flight: no new request while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while a result is pending");

  a_recycled_granted: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.recycled) |-> rsp_data.granted)
    else $error("recycled without grant");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_data.granted) |-> (rsp_data.granted_slot == '0))
    else $error("slot number on a failed request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
    else $error("stalled result changed");

endmodule

bind slot_pool_oldest_recycle_top spor_checker u_spor_checker (
  .clk      (clk),
  .rst      (rst),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp_data (rsp_data)
);
`default_nettype wire
